>>> sv/vkd_pkg.sv
// vkd_pkg: shared types and constants for the vt100 key sequence decoder
// holds item, result and job structs, key codes and parser phases
// no dependencies
`default_nettype none

package vkd_pkg;

	localparam int QueueDepth = 4;

	localparam logic FuncByte = 1'b0;
	localparam logic FuncGap  = 1'b1;

	localparam logic [4:0] KeyChar      = 5'd0;
	localparam logic [4:0] KeyEnter     = 5'd1;
	localparam logic [4:0] KeyBackspace = 5'd2;
	localparam logic [4:0] KeyEscape    = 5'd3;
	localparam logic [4:0] KeyUp        = 5'd4;
	localparam logic [4:0] KeyDown      = 5'd5;
	localparam logic [4:0] KeyRight     = 5'd6;
	localparam logic [4:0] KeyLeft      = 5'd7;
	localparam logic [4:0] KeyF1        = 5'd8;
	localparam logic [4:0] KeyF9        = 5'd16;
	localparam logic [4:0] KeyInsert    = 5'd20;
	localparam logic [4:0] KeyDelete    = 5'd21;
	localparam logic [4:0] KeyPgUp      = 5'd22;
	localparam logic [4:0] KeyPgDn      = 5'd23;
	localparam logic [4:0] KeyHome      = 5'd24;
	localparam logic [4:0] KeyEnd       = 5'd25;
	localparam logic [4:0] KeyUnsup     = 5'd26;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_ESC     = 4'd1,
		PH_SS3     = 4'd2,
		PH_CSI     = 4'd3,
		PH_ONE     = 4'd4,
		PH_ONE_T   = 4'd5,
		PH_TWO     = 4'd6,
		PH_TWO_T   = 4'd7,
		PH_TILDE   = 4'd8
	} phase_t;

	typedef struct packed {
		logic       func;
		logic [7:0] byte_value;
	} in_item_t;

	typedef struct packed {
		logic [4:0] key_code;
		logic [7:0] char_byte;
		logic       last_of_run;
	} out_item_t;

	// escape_first: an escape result goes out ahead of key/chr
	typedef struct packed {
		logic       escape_first;
		logic [4:0] key;
		logic [7:0] chr;
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

`default_nettype wire

>>> sv/vkd_front.sv
// vkd_front: byte parser, tracks the sequence phase and emits decode jobs
// depends on vkd_pkg
`default_nettype none

module vkd_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire vkd_pkg::in_item_t item,
	output vkd_pkg::job_t         job,
	output logic                  job_valid
);
	import vkd_pkg::*;

	localparam logic [7:0] ByteLf    = 8'h0a;
	localparam logic [7:0] ByteBs    = 8'h08;
	localparam logic [7:0] ByteDel   = 8'h7f;
	localparam logic [7:0] ByteEsc   = 8'h1b;
	localparam logic [7:0] ByteTilde = 8'h7e;
	localparam logic [7:0] ByteO     = 8'h4f;
	localparam logic [7:0] ByteLbr   = 8'h5b;
	localparam logic [7:0] ByteP     = 8'h50;
	localparam logic [7:0] ByteS     = 8'h53;
	localparam logic [7:0] ByteA     = 8'h41;
	localparam logic [7:0] ByteB     = 8'h42;
	localparam logic [7:0] ByteC     = 8'h43;
	localparam logic [7:0] ByteD     = 8'h44;
	localparam logic [7:0] ByteF     = 8'h46;
	localparam logic [7:0] ByteH     = 8'h48;
	localparam logic [7:0] Dig0      = 8'h30;
	localparam logic [7:0] Dig1      = 8'h31;
	localparam logic [7:0] Dig2      = 8'h32;
	localparam logic [7:0] Dig3      = 8'h33;
	localparam logic [7:0] Dig4      = 8'h34;
	localparam logic [7:0] Dig5      = 8'h35;
	localparam logic [7:0] Dig6      = 8'h36;
	localparam logic [7:0] Dig7      = 8'h37;
	localparam logic [7:0] Dig8      = 8'h38;
	localparam logic [7:0] Dig9      = 8'h39;

	phase_t     phase_q, phase_d;
	logic [7:0] held_q, held_d;
	logic [7:0] b;

	function automatic logic [4:0] one_key(input logic [7:0] d);
		logic [4:0] k;
		case (d)
			Dig1: k = KeyF1;
			Dig2: k = KeyF1 + 5'd1;
			Dig3: k = KeyF1 + 5'd2;
			Dig4: k = KeyF1 + 5'd3;
			Dig5: k = KeyF1 + 5'd4;
			Dig7: k = KeyF1 + 5'd5;
			Dig8: k = KeyF1 + 5'd6;
			Dig9: k = KeyF1 + 5'd7;
			default: k = KeyUnsup;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] two_key(input logic [7:0] d);
		logic [4:0] k;
		case (d)
			Dig0: k = KeyF9;
			Dig1: k = KeyF9 + 5'd1;
			Dig3: k = KeyF9 + 5'd2;
			Dig4: k = KeyF9 + 5'd3;
			default: k = KeyUnsup;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] tilde_key(input logic [7:0] d);
		logic [4:0] k;
		case (d)
			Dig3: k = KeyDelete;
			Dig5: k = KeyPgUp;
			Dig6: k = KeyPgDn;
			Dig7: k = KeyHome;
			Dig8: k = KeyEnd;
			default: k = KeyUnsup;
		endcase
		return k;
	endfunction

	assign b = item.byte_value;

	// next state
	always_comb begin
		phase_d = phase_q;
		held_d  = held_q;
		if (item.func == FuncGap) begin
			if (phase_q == PH_ESC) begin
				phase_d = PH_IDLE;
			end
		end else begin
			case (phase_q)
				PH_ESC: begin
					if (b == ByteO) begin
						phase_d = PH_SS3;
					end else if (b == ByteLbr) begin
						phase_d = PH_CSI;
					end else if (b == ByteEsc) begin
						phase_d = PH_ESC;
					end else begin
						phase_d = PH_IDLE;
					end
				end
				PH_CSI: begin
					case (b)
						Dig1: phase_d = PH_ONE;
						Dig2: phase_d = PH_TWO;
						Dig3, Dig5, Dig6, Dig7, Dig8: begin
							phase_d = PH_TILDE;
							held_d  = b;
						end
						default: phase_d = PH_IDLE;
					endcase
				end
				PH_ONE: begin
					held_d  = b;
					phase_d = PH_ONE_T;
				end
				PH_TWO: begin
					if (b == Dig0 || b == Dig1 || b == Dig3 || b == Dig4) begin
						held_d  = b;
						phase_d = PH_TWO_T;
					end else begin
						phase_d = PH_IDLE;
					end
				end
				PH_SS3, PH_ONE_T, PH_TWO_T, PH_TILDE: phase_d = PH_IDLE;
				default: phase_d = (b == ByteEsc) ? PH_ESC : PH_IDLE;
			endcase
		end
	end

	// job outputs
	always_comb begin
		job_valid        = 1'b0;
		job.escape_first = 1'b0;
		job.key          = KeyUnsup;
		job.chr          = 8'd0;
		if (item.func == FuncGap) begin
			if (phase_q == PH_ESC) begin
				job_valid = 1'b1;
				job.key   = KeyEscape;
			end
		end else begin
			case (phase_q)
				PH_ESC: begin
					if (b == ByteEsc) begin
						job_valid = 1'b1;
						job.key   = KeyEscape;
					end else if (b != ByteO && b != ByteLbr) begin
						job_valid        = 1'b1;
						job.escape_first = 1'b1;
						if (b == ByteLf) begin
							job.key = KeyEnter;
						end else if (b == ByteDel || b == ByteBs) begin
							job.key = KeyBackspace;
						end else begin
							job.key = KeyChar;
							job.chr = b;
						end
					end
				end
				PH_SS3: begin
					job_valid = 1'b1;
					if (b >= ByteP && b <= ByteS) begin
						job.key = KeyF1 + {3'd0, b[1:0]};
					end
				end
				PH_CSI: begin
					case (b)
						ByteA: begin job_valid = 1'b1; job.key = KeyUp;    end
						ByteB: begin job_valid = 1'b1; job.key = KeyDown;  end
						ByteC: begin job_valid = 1'b1; job.key = KeyRight; end
						ByteD: begin job_valid = 1'b1; job.key = KeyLeft;  end
						ByteF: begin job_valid = 1'b1; job.key = KeyEnd;   end
						ByteH: begin job_valid = 1'b1; job.key = KeyHome;  end
						Dig1, Dig2, Dig3, Dig5, Dig6, Dig7, Dig8: job_valid = 1'b0;
						default: job_valid = 1'b1;
					endcase
				end
				PH_ONE: job_valid = 1'b0;
				PH_ONE_T: begin
					job_valid = 1'b1;
					if (b == ByteTilde) begin
						job.key = one_key(held_q);
					end
				end
				PH_TWO: begin
					if (b == ByteTilde) begin
						job_valid = 1'b1;
						job.key   = KeyInsert;
					end else if (b == Dig0 || b == Dig1 || b == Dig3 || b == Dig4) begin
						job_valid = 1'b0;
					end else begin
						job_valid = 1'b1;
					end
				end
				PH_TWO_T: begin
					job_valid = 1'b1;
					if (b == ByteTilde) begin
						job.key = two_key(held_q);
					end
				end
				PH_TILDE: begin
					job_valid = 1'b1;
					if (b == ByteTilde) begin
						job.key = tilde_key(held_q);
					end
				end
				default: begin
					if (b == ByteLf) begin
						job_valid = 1'b1;
						job.key   = KeyEnter;
					end else if (b == ByteDel || b == ByteBs) begin
						job_valid = 1'b1;
						job.key   = KeyBackspace;
					end else if (b != ByteEsc) begin
						job_valid = 1'b1;
						job.key   = KeyChar;
						job.chr   = b;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

endmodule

`default_nettype wire

>>> sv/vkd_queue.sv
// vkd_queue: short job queue between the parser and the result stage
// depends on vkd_pkg
`default_nettype none

module vkd_queue #(
	parameter int DEPTH = vkd_pkg::QueueDepth
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire vkd_pkg::job_t  wr_job,
	input  wire logic           rd_en,
	output vkd_pkg::job_t       rd_job,
	output vkd_pkg::q_status_t  status
);
	import vkd_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	job_t            jobs_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_wr, do_rd;

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == FullCnt);
	assign do_wr        = wr_en && !status.full;
	assign do_rd        = rd_en && !status.empty;
	assign rd_job       = jobs_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			jobs_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/vkd_back.sv
// vkd_back: expands queued jobs into result beats and holds the output register
// depends on vkd_pkg
`default_nettype none

module vkd_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire vkd_pkg::job_t      job,
	input  wire vkd_pkg::q_status_t qstat,
	output logic                    job_done,
	input  wire logic               pop,
	output logic                    empty,
	output vkd_pkg::out_item_t      result
);
	import vkd_pkg::*;

	logic      out_valid_q;
	out_item_t out_q;
	logic      second_q;
	logic      load;
	logic      esc_beat;
	out_item_t nxt;

	assign load     = !qstat.empty && (!out_valid_q || pop);
	assign esc_beat = job.escape_first && !second_q;
	assign job_done = load && !esc_beat;

	always_comb begin
		if (esc_beat) begin
			nxt.key_code    = KeyEscape;
			nxt.char_byte   = 8'd0;
			nxt.last_of_run = 1'b0;
		end else begin
			nxt.key_code    = job.key;
			nxt.char_byte   = (job.key == KeyChar) ? job.chr : 8'd0;
			nxt.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				second_q    <= esc_beat;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= nxt;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

`default_nettype wire

>>> sv/vt100_key_sequence_decoder_core.sv
// vt100_key_sequence_decoder_core: top level of the vt100 key sequence decoder
// path: an accepted item's job is written to the job queue, then loaded into the output register
// throughput: one item per cycle while the queue is not full; an item that yields two results
// holds the result stage for both of its beats, absorbed by the job queue (QUEUE_DEPTH entries)
// reset: parser returns to idle with held digit zero, queue and output register empty
// depends on vkd_pkg, vkd_front, vkd_queue, vkd_back
`default_nettype none

module vt100_key_sequence_decoder_core #(
	parameter int QUEUE_DEPTH = vkd_pkg::QueueDepth
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire vkd_pkg::in_item_t   item,
	output logic                     empty,
	input  wire logic                pop,
	output vkd_pkg::out_item_t       result
);
	import vkd_pkg::*;

	logic      accept;
	job_t      front_job;
	logic      front_job_valid;
	job_t      head_job;
	q_status_t qstat;
	logic      job_done;

	assign full   = qstat.full;
	assign accept = push && !qstat.full;

	vkd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.job       (front_job),
		.job_valid (front_job_valid)
	);

	vkd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept && front_job_valid),
		.wr_job (front_job),
		.rd_en  (job_done),
		.rd_job (head_job),
		.status (qstat)
	);

	vkd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (head_job),
		.qstat    (qstat),
		.job_done (job_done),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.key_code <= KeyUnsup)
		else $error("key code out of range");

	a_char_only_raw: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.char_byte != 8'd0) |-> result.key_code == KeyChar)
		else $error("char byte set on non-char key");

	a_first_is_escape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.last_of_run) |-> result.key_code == KeyEscape)
		else $error("leading beat of a pair is not escape");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !result.last_of_run) |=> !empty)
		else $error("second beat of a pair missing");

endmodule

`default_nettype wire
